// ===== src/lcfb_pkg.sv =====
// Shared types and constants for the LED cross-fade frame blender.
package lcfb_pkg;

    localparam int PIXEL_W         = 24;
    localparam int CHAN_W          = 8;
    localparam int IDX_W           = 7;
    localparam int COUNT_W         = 8;
    localparam int DECAY_W         = 16;
    localparam int DECAY_FRAC_BITS = 16;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_IDX_W       = 1;

    // Multiplier operand A carries either a signed 9-bit channel difference
    // or the unsigned 16-bit decay factor.
    localparam int MAC_A_W = DECAY_W + 1;

    localparam logic [COUNT_W-1:0] PIXEL_COUNT_RST = 8'd114;
    localparam logic [DECAY_W-1:0] DECAY_RST       = 16'd58982;

    typedef enum logic [1:0]
    {
        MODE_SET    = 2'd0,
        MODE_COMMIT = 2'd1,
        MODE_TICK   = 2'd2,
        MODE_RENDER = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_PIXEL_COUNT  = 1'b0,
        REG_DECAY_FACTOR = 1'b1
    } cfg_reg_t;

endpackage

// ===== src/lcfb_ram.sv =====
// Pixel store: one write port, one registered read port with enable.
module lcfb_ram
    import lcfb_pkg::*;
#(
    parameter int DEPTH = 128,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic               clk,
    input  logic               we,
    input  logic [ADDR_W-1:0]  waddr,
    input  logic [PIXEL_W-1:0] wdata,
    input  logic               re,
    input  logic [ADDR_W-1:0]  raddr,
    output logic [PIXEL_W-1:0] rdata
);

    logic [PIXEL_W-1:0] mem [DEPTH];
    logic [PIXEL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/lcfb_mac.sv =====
// Shared multiply-add unit with a registered result: p = a * b + c.
module lcfb_mac
    import lcfb_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    localparam int B_W = FRAC_BITS + 2,
    localparam int P_W = MAC_A_W + B_W
)
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [MAC_A_W-1:0] a,
    input  logic signed [B_W-1:0]     b,
    input  logic signed [P_W-1:0]     c,
    output logic signed [P_W-1:0]     p
);

    logic signed [P_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= a * b + c;
        end
    end

    assign p = p_reg;

endmodule

// ===== src/led_crossfade_frame_blender_core.sv =====
// Top level of the LED cross-fade frame blender: sequencer, registers and stores.
//
// The block holds three pixel stores (source, shown, pending) and a fade level
// with FADE_FRAC_BITS fraction bits. Items arrive on the in_valid/in_stall
// channel; the mode field selects set pending colour, commit, frame tick or
// render. Only render items with an index below min(pixel_count, MAX_PIXELS)
// produce a beat on the out channel, in G,R,B order. All blending and the
// decay multiply go through one shared multiply-add unit, one colour channel
// per cycle, so the block works on one item at a time and holds in_stall high
// until it is done. A render finishes only once the output register is free to
// take its result, and a commit works through every pixel in use. After reset
// the block zeroes the stores, one address per cycle, before it accepts the
// first item; configuration writes are taken at any time and cfg_ready is
// always high. Write configuration only while idle.
module led_crossfade_frame_blender_core
    import lcfb_pkg::*;
#(
    parameter int MAX_PIXELS     = 128,
    parameter int FADE_FRAC_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            mode,
    input  logic [IDX_W-1:0]      pixel_index,
    input  logic [CHAN_W-1:0]     red,
    input  logic [CHAN_W-1:0]     green,
    input  logic [CHAN_W-1:0]     blue,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [IDX_W-1:0]      out_index,
    output logic [CHAN_W-1:0]     out_green,
    output logic [CHAN_W-1:0]     out_red,
    output logic [CHAN_W-1:0]     out_blue
);

    localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int FADE_W = FADE_FRAC_BITS + 1;
    localparam int B_W    = FADE_FRAC_BITS + 2;
    localparam int P_W    = MAC_A_W + B_W;

    localparam logic [CMP_W-1:0]  MAX_CMP   = CMP_W'(MAX_PIXELS);
    localparam logic [CNT_W-1:0]  CLR_LAST  = CNT_W'(MAX_PIXELS - 1);
    localparam logic [FADE_W-1:0] FADE_ONE  = {1'b1, {FADE_FRAC_BITS{1'b0}}};

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_TICK_WB,
        ST_CMT_RD,
        ST_BLEND
    } state_t;

    function automatic logic [CHAN_W-1:0] pick_chan(input logic [PIXEL_W-1:0] px,
                                                    input logic [1:0] sel);
        logic [CHAN_W-1:0] res;
        case (sel)
            2'd0:    res = px[23:16];
            2'd1:    res = px[15:8];
            default: res = px[7:0];
        endcase
        return res;
    endfunction

    // Registers
    state_t              state_reg, state_next;
    logic [1:0]          ch_reg, ch_next;
    logic [CNT_W-1:0]    ptr_reg, ptr_next;
    logic                commit_reg, commit_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CHAN_W-1:0]   blend_r_reg, blend_r_next;
    logic [CHAN_W-1:0]   blend_g_reg, blend_g_next;
    logic [FADE_W-1:0]   fade_reg, fade_next;
    logic [COUNT_W-1:0]  pixel_count_reg, pixel_count_next;
    logic [DECAY_W-1:0]  decay_reg, decay_next;
    logic                out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]    out_index_reg, out_index_next;
    logic [CHAN_W-1:0]   out_green_reg, out_green_next;
    logic [CHAN_W-1:0]   out_red_reg, out_red_next;
    logic [CHAN_W-1:0]   out_blue_reg, out_blue_next;

    // Store ports
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic                rd_en;
    logic                src_we, shw_we, pnd_we;
    logic [PIXEL_W-1:0]  src_wdata, shw_wdata, pnd_wdata;
    logic [PIXEL_W-1:0]  src_rd, shw_rd, pnd_rd;

    // Shared multiply-add
    logic                      mac_en;
    logic signed [MAC_A_W-1:0] mac_a;
    logic signed [B_W-1:0]     mac_b;
    logic signed [P_W-1:0]     mac_c;
    logic signed [P_W-1:0]     mac_p;

    // Helpers
    logic [CMP_W-1:0]    count_ext;
    logic [CMP_W-1:0]    n_eff;
    logic                idx_in_range;
    logic                ptr_in_range;
    logic [ADDR_W-1:0]   in_addr;
    logic [CHAN_W-1:0]   src_ch, tgt_ch;
    logic [CHAN_W:0]     diff;
    logic [CHAN_W-1:0]   blend_ch;
    logic                out_free;

    lcfb_ram #(.DEPTH(MAX_PIXELS)) u_src_ram
    (
        .clk   (clk),
        .we    (src_we),
        .waddr (wr_addr),
        .wdata (src_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (src_rd)
    );

    lcfb_ram #(.DEPTH(MAX_PIXELS)) u_shw_ram
    (
        .clk   (clk),
        .we    (shw_we),
        .waddr (wr_addr),
        .wdata (shw_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (shw_rd)
    );

    lcfb_ram #(.DEPTH(MAX_PIXELS)) u_pnd_ram
    (
        .clk   (clk),
        .we    (pnd_we),
        .waddr (wr_addr),
        .wdata (pnd_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (pnd_rd)
    );

    lcfb_mac #(.FRAC_BITS(FADE_FRAC_BITS)) u_mac
    (
        .clk (clk),
        .en  (mac_en),
        .a   (mac_a),
        .b   (mac_b),
        .c   (mac_c),
        .p   (mac_p)
    );

    // Pixels in use: min(pixel_count, MAX_PIXELS)
    assign count_ext    = CMP_W'(pixel_count_reg);
    assign n_eff        = (count_ext < MAX_CMP) ? count_ext : MAX_CMP;
    assign idx_in_range = CMP_W'(pixel_index) < n_eff;
    assign ptr_in_range = CMP_W'(ptr_reg) < n_eff;
    assign in_addr      = ADDR_W'(pixel_index);

    // Channel blend: t*ONE + (s - t)*fade, then drop the fraction bits
    assign src_ch   = pick_chan(src_rd, ch_reg);
    assign tgt_ch   = pick_chan(shw_rd, ch_reg);
    assign diff     = {1'b0, src_ch} - {1'b0, tgt_ch};
    assign blend_ch = mac_p[FADE_FRAC_BITS +: CHAN_W];
    assign mac_b    = {1'b0, fade_reg};

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next       = state_reg;
        ch_next          = ch_reg;
        ptr_next         = ptr_reg;
        commit_next      = commit_reg;
        idx_next         = idx_reg;
        blend_r_next     = blend_r_reg;
        blend_g_next     = blend_g_reg;
        fade_next        = fade_reg;
        pixel_count_next = pixel_count_reg;
        decay_next       = decay_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_index_next   = out_index_reg;
        out_green_next   = out_green_reg;
        out_red_next     = out_red_reg;
        out_blue_next    = out_blue_reg;

        wr_addr   = ptr_reg[ADDR_W-1:0];
        rd_addr   = ptr_reg[ADDR_W-1:0];
        rd_en     = 1'b0;
        src_we    = 1'b0;
        shw_we    = 1'b0;
        pnd_we    = 1'b0;
        src_wdata = {blend_r_reg, blend_g_reg, blend_ch};
        shw_wdata = pnd_rd;
        pnd_wdata = {red, green, blue};

        mac_en = 1'b0;
        mac_a  = {{(MAC_A_W - CHAN_W - 1){diff[CHAN_W]}}, diff};
        mac_c  = {{(P_W - CHAN_W - FADE_FRAC_BITS){1'b0}}, tgt_ch, {FADE_FRAC_BITS{1'b0}}};

        // Configuration writes land whenever they come
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PIXEL_COUNT:  pixel_count_next = cfg_data[COUNT_W-1:0];
                REG_DECAY_FACTOR: decay_next       = cfg_data[DECAY_W-1:0];
                default:          ;
            endcase
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // Zero all three stores, one address a cycle
                src_we    = 1'b1;
                shw_we    = 1'b1;
                pnd_we    = 1'b1;
                src_wdata = '0;
                shw_wdata = '0;
                pnd_wdata = '0;
                if (ptr_reg == CLR_LAST)
                begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (mode_t'(mode))
                        MODE_SET:
                        begin
                            if (idx_in_range)
                            begin
                                pnd_we  = 1'b1;
                                wr_addr = in_addr;
                            end
                        end
                        MODE_COMMIT:
                        begin
                            ptr_next   = '0;
                            state_next = ST_CMT_RD;
                        end
                        MODE_TICK:
                        begin
                            mac_en     = 1'b1;
                            mac_a      = {1'b0, decay_reg};
                            mac_c      = '0;
                            state_next = ST_TICK_WB;
                        end
                        MODE_RENDER:
                        begin
                            if (idx_in_range)
                            begin
                                rd_en       = 1'b1;
                                rd_addr     = in_addr;
                                idx_next    = pixel_index;
                                commit_next = 1'b0;
                                ch_next     = 2'd0;
                                state_next  = ST_BLEND;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_TICK_WB:
            begin
                // Product never exceeds the old fade level, so the slice holds it
                fade_next  = mac_p[DECAY_FRAC_BITS +: FADE_W];
                state_next = ST_IDLE;
            end

            ST_CMT_RD:
            begin
                if (ptr_in_range)
                begin
                    rd_en       = 1'b1;
                    commit_next = 1'b1;
                    ch_next     = 2'd0;
                    state_next  = ST_BLEND;
                end
                else
                begin
                    fade_next  = FADE_ONE;
                    state_next = ST_IDLE;
                end
            end

            ST_BLEND:
            begin
                // Issue channel ch, collect channel ch-1 from the unit
                if (ch_reg != 2'd3)
                begin
                    mac_en  = 1'b1;
                    ch_next = ch_reg + 1'b1;
                end
                if (ch_reg == 2'd1)
                begin
                    blend_r_next = blend_ch;
                end
                if (ch_reg == 2'd2)
                begin
                    blend_g_next = blend_ch;
                end
                if (ch_reg == 2'd3)
                begin
                    if (commit_reg)
                    begin
                        src_we     = 1'b1;
                        shw_we     = 1'b1;
                        ptr_next   = ptr_reg + 1'b1;
                        state_next = ST_CMT_RD;
                    end
                    else if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_index_next = idx_reg;
                        out_red_next   = blend_r_reg;
                        out_green_next = blend_g_reg;
                        out_blue_next  = blend_ch;
                        state_next     = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            ch_reg          <= '0;
            ptr_reg         <= '0;
            commit_reg      <= 1'b0;
            idx_reg         <= '0;
            blend_r_reg     <= '0;
            blend_g_reg     <= '0;
            fade_reg        <= '0;
            pixel_count_reg <= PIXEL_COUNT_RST;
            decay_reg       <= DECAY_RST;
            out_valid_reg   <= 1'b0;
            out_index_reg   <= '0;
            out_green_reg   <= '0;
            out_red_reg     <= '0;
            out_blue_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            ch_reg          <= ch_next;
            ptr_reg         <= ptr_next;
            commit_reg      <= commit_next;
            idx_reg         <= idx_next;
            blend_r_reg     <= blend_r_next;
            blend_g_reg     <= blend_g_next;
            fade_reg        <= fade_next;
            pixel_count_reg <= pixel_count_next;
            decay_reg       <= decay_next;
            out_valid_reg   <= out_valid_next;
            out_index_reg   <= out_index_next;
            out_green_reg   <= out_green_next;
            out_red_reg     <= out_red_next;
            out_blue_reg    <= out_blue_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_green = out_green_reg;
    assign out_red   = out_red_reg;
    assign out_blue  = out_blue_reg;

endmodule
